@@ design/assert_macros.svh @@
// Assertion helper macros for the ordered array table engine.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define OAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/oat_pkg.sv @@
// Shared constants and codes for the ordered array table engine.
// No dependencies; used by oat_ram, oat_ctrl and the top level.
package oat_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_LSEARCH = 2'd2,
        KIND_BSEARCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

@@ design/ordered_array_table_engine_core.sv @@
// Ordered array table engine: packed signed table with insert, delete and two searches.
// Depends on oat_pkg, oat_ram, oat_ctrl and assert_macros.svh.
//
// One item at a time. The entries live in a one-read, one-write memory with a
// registered read; the sequencer streams shifts at one entry a cycle. A rejected
// item or a delete of the last entry goes straight to the result; an insert shifts
// the entries from the position up, then writes the value (an append only writes);
// a delete shifts later entries down; linear search scans, binary search probes.
// The result sits in an output register, so the next item is taken while it waits.
// No clearing pass after reset: only slots below the count are ever read.
`include "assert_macros.svh"

module ordered_array_table_engine_core #(
    parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic [$clog2(DEPTH+1)-1:0]        i_position,
    input  logic signed [oat_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [$clog2(DEPTH)-1:0]          o_found_index,
    output logic [$clog2(DEPTH+1)-1:0]        o_entry_total
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic                              w_wr_en, w_rd_en;
    logic [AW-1:0]                     w_wr_addr, w_rd_addr;
    logic signed [oat_pkg::DATA_W-1:0] w_wr_data, w_rd_data;
    logic                              w_res_valid, w_res_free;
    logic [1:0]                        w_res_status;
    logic [AW-1:0]                     w_res_index;
    logic [CW-1:0]                     w_res_total;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status;
    logic [AW-1:0] r_index;
    logic [CW-1:0] r_total;

    oat_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    oat_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_res_free   (w_res_free),
        .o_res_valid  (w_res_valid),
        .o_res_status (w_res_status),
        .o_res_index  (w_res_index),
        .o_res_total  (w_res_total),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data)
    );

    // output slot is free when empty or being taken this cycle
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_free) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_free) begin
            r_status <= w_res_status;
            r_index  <= w_res_index;
            r_total  <= w_res_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_index;
    assign o_entry_total = r_total;

    `OAT_ASSERT_NOW(a_total_bound, o_out_valid,
        o_entry_total <= CW'(DEPTH), "entry total above depth")
    `OAT_ASSERT_NOW(a_full_total, o_out_valid && (o_status == oat_pkg::ST_FULL),
        o_entry_total == CW'(DEPTH), "full status without full table")
    `OAT_ASSERT_NOW(a_miss_index, o_out_valid && (o_status != oat_pkg::ST_OK),
        o_found_index == '0, "nonzero index on failed item")
    `OAT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall,
        o_in_stall, "second item taken while busy")

endmodule

@@ design/oat_ram.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on oat_pkg for the data width.
module oat_ram #(
    parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic signed [oat_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic signed [oat_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [oat_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ design/oat_ctrl.sv @@
// Operation sequencer: shifts, linear scan and binary search over the entry store.
// Depends on oat_pkg; drives the ports of oat_ram.
module oat_ctrl #(
    parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item in
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_kind,
    input  logic [$clog2(DEPTH+1)-1:0]           i_position,
    input  logic signed [oat_pkg::DATA_W-1:0]    i_value,
    // result out
    input  logic                                 i_res_free,
    output logic                                 o_res_valid,
    output logic [1:0]                           o_res_status,
    output logic [$clog2(DEPTH)-1:0]             o_res_index,
    output logic [$clog2(DEPTH+1)-1:0]           o_res_total,
    // memory
    output logic                                 o_wr_en,
    output logic [$clog2(DEPTH)-1:0]             o_wr_addr,
    output logic signed [oat_pkg::DATA_W-1:0]    o_wr_data,
    output logic                                 o_rd_en,
    output logic [$clog2(DEPTH)-1:0]             o_rd_addr,
    input  logic signed [oat_pkg::DATA_W-1:0]    i_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MOVE  = 8'b0000_0010,
        S_DRAIN = 8'b0000_0100,
        S_PUT   = 8'b0000_1000,
        S_LSCAN = 8'b0001_0000,
        S_BREAD = 8'b0010_0000,
        S_BCMP  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                            r_state, n_state;
    oat_pkg::t_kind                    r_kind, n_kind;
    logic [CW-1:0]                     r_pos, n_pos;
    logic signed [oat_pkg::DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [CW-1:0]                     r_ptr, n_ptr;
    logic                              r_mv_pend, n_mv_pend;
    logic [AW-1:0]                     r_mv_addr, n_mv_addr;
    logic                              r_cmp, n_cmp;
    logic [AW-1:0]                     r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]                     r_lo, n_lo;
    logic [CW-1:0]                     r_hx, n_hx;     // exclusive upper bound
    logic [AW-1:0]                     r_mid, n_mid;
    oat_pkg::t_status                  r_status, n_status;
    logic [AW-1:0]                     r_index, n_index;

    logic          w_accept;
    logic          w_issue;
    logic [CW:0]   w_sum;
    logic [AW-1:0] w_mid;
    logic [CW-1:0] w_lo_nx, w_hx_nx;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_issue  = (r_ptr < r_cnt);
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hx} - (CW+1)'(1);
    assign w_mid    = w_sum[AW:1];
    // next bounds from this compare: right when entry below key, else left
    assign w_lo_nx  = (i_rd_data < r_val) ? CW'({1'b0, r_mid} + 1'b1) : r_lo;
    assign w_hx_nx  = (i_rd_data > r_val) ? CW'(r_mid) : r_hx;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_pos     = r_pos;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_mv_pend = 1'b0;
        n_mv_addr = r_mv_addr;
        n_cmp     = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_lo      = r_lo;
        n_hx      = r_hx;
        n_mid     = r_mid;
        n_status  = r_status;
        n_index   = r_index;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr[AW-1:0];
        // pending shift write lands in the cycle after its read
        o_wr_en   = r_mv_pend;
        o_wr_addr = r_mv_addr;
        o_wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = oat_pkg::t_kind'(i_kind);
                    n_pos    = i_position;
                    n_val    = i_value;
                    n_status = oat_pkg::ST_OK;
                    n_index  = '0;
                    n_state  = S_DONE;
                    unique case (oat_pkg::t_kind'(i_kind))
                        oat_pkg::KIND_INSERT: begin
                            if (i_position > r_cnt) begin
                                n_status = oat_pkg::ST_BAD_POS;
                            end else if (r_cnt == CW'(DEPTH)) begin
                                n_status = oat_pkg::ST_FULL;
                            end else if (i_position == r_cnt) begin
                                n_state = S_PUT;
                            end else begin
                                n_ptr   = r_cnt - CW'(1);
                                n_state = S_MOVE;
                            end
                        end
                        oat_pkg::KIND_DELETE: begin
                            if (i_position >= r_cnt) begin
                                n_status = oat_pkg::ST_BAD_POS;
                            end else if (i_position == r_cnt - CW'(1)) begin
                                n_cnt = r_cnt - CW'(1);
                            end else begin
                                n_ptr   = i_position + CW'(1);
                                n_state = S_MOVE;
                            end
                        end
                        oat_pkg::KIND_LSEARCH: begin
                            if (r_cnt == '0) begin
                                n_status = oat_pkg::ST_NOT_FOUND;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_LSCAN;
                            end
                        end
                        oat_pkg::KIND_BSEARCH: begin
                            if (r_cnt == '0) begin
                                n_status = oat_pkg::ST_NOT_FOUND;
                            end else begin
                                n_lo    = '0;
                                n_hx    = r_cnt;
                                n_state = S_BREAD;
                            end
                        end
                        default: n_status = oat_pkg::ST_NOT_FOUND;
                    endcase
                end
            end
            S_MOVE: begin
                // read and write addresses never coincide: writes trail reads
                o_rd_en   = 1'b1;
                n_mv_pend = 1'b1;
                if (r_kind == oat_pkg::KIND_INSERT) begin
                    n_mv_addr = AW'(r_ptr + CW'(1));
                    if (r_ptr == r_pos) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ptr = r_ptr - CW'(1);
                    end
                end else begin
                    n_mv_addr = AW'(r_ptr - CW'(1));
                    if (r_ptr == r_cnt - CW'(1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (r_kind == oat_pkg::KIND_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos[AW-1:0];
                o_wr_data = r_val;
                n_cnt     = r_cnt + CW'(1);
                n_state   = S_DONE;
            end
            S_LSCAN: begin
                o_rd_en   = w_issue;
                n_cmp     = w_issue;
                n_cmp_idx = r_ptr[AW-1:0];
                if (w_issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_cmp && (i_rd_data == r_val)) begin
                    n_index = r_cmp_idx;
                    n_cmp   = 1'b0;
                    n_state = S_DONE;
                end else if (!w_issue && !r_cmp) begin
                    n_status = oat_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_BREAD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = w_mid;
                n_mid     = w_mid;
                n_state   = S_BCMP;
            end
            S_BCMP: begin
                if (i_rd_data == r_val) begin
                    n_index = r_mid;
                    n_state = S_DONE;
                end else begin
                    n_lo = w_lo_nx;
                    n_hx = w_hx_nx;
                    if (w_lo_nx < w_hx_nx) begin
                        n_state = S_BREAD;
                    end else begin
                        n_status = oat_pkg::ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_mv_pend <= 1'b0;
            r_cmp     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_mv_pend <= n_mv_pend;
            r_cmp     <= n_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_mv_addr <= n_mv_addr;
        r_cmp_idx <= n_cmp_idx;
        r_lo      <= n_lo;
        r_hx      <= n_hx;
        r_mid     <= n_mid;
        r_status  <= n_status;
        r_index   <= n_index;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_status = r_status;
    assign o_res_index  = (r_status == oat_pkg::ST_OK) ? r_index : '0;
    assign o_res_total  = r_cnt;

endmodule
